// ===== rtl/core/rrtq_pkg.sv =====
// Shared types and codes for the round-robin task queue.
// Depends on nothing; imported by the controller, the datapath and the top level.
`default_nettype none

package rrtq_pkg;

  localparam int PID_W = 16;

  // Request kinds
  localparam logic [2:0] KIND_START = 3'd0;
  localparam logic [2:0] KIND_SPAWN = 3'd1;
  localparam logic [2:0] KIND_SCHED = 3'd2;
  localparam logic [2:0] KIND_EXIT  = 3'd3;
  localparam logic [2:0] KIND_KILL  = 3'd4;
  localparam logic [2:0] KIND_QUERY = 3'd5;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_REFUSED = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  typedef struct packed {
    logic [2:0]       kind;
    logic [1:0]       core;
    logic [PID_W-1:0] target_pid;
  } rrtq_in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [PID_W-1:0] pid;
    logic [PID_W-1:0] prev_pid;
  } rrtq_out_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_REPLY,
    OP_START,
    OP_SPAWN,
    OP_HEAD_RD,
    OP_POP,
    OP_SWAP,
    OP_EXIT,
    OP_QUERY,
    OP_KC_CLR,
    OP_KC_NEXT,
    OP_KC_HIT,
    OP_KQ_CLR,
    OP_KQ_RD,
    OP_KQ_NEXT,
    OP_KQ_HIT,
    OP_LOAD
  } rrtq_op_t;

  typedef struct packed {
    rrtq_op_t   op;
    logic       scan;
    logic [1:0] status;
  } rrtq_cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       core_ok;
    logic       id_avail;
    logic       q_full;
    logic       q_empty;
    logic       run_zero;
    logic       head_dead;
    logic       kc_end;
    logic       kc_match;
    logic       kq_end;
    logic       kq_match;
    logic       target_zero;
    logic       out_free;
  } rrtq_flags_t;

endpackage

`default_nettype wire

// ===== rtl/core/rrtq_ctrl.sv =====
// Sequencer for the round-robin task queue: decodes a request and steps the datapath.
// Depends on rrtq_pkg.
`default_nettype none

module rrtq_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  rrtq_pkg::rrtq_flags_t flags,
  output logic                 in_ready,
  output rrtq_pkg::rrtq_cmd_t  cmd
);
  import rrtq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCH_RD,
    S_SCH_CHK,
    S_KC_CHK,
    S_KQ_RD,
    S_KQ_CHK,
    S_RESP
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;

  always_comb begin
    state_nxt  = state_r;
    cmd.op     = OP_NONE;
    cmd.scan   = 1'b0;
    cmd.status = ST_OK;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LATCH;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_RESP;
        case (flags.kind)
          KIND_START: begin
            if (!flags.core_ok) begin
              cmd.op = OP_REPLY; cmd.status = ST_MISSING;
            end else if (!flags.id_avail) begin
              cmd.op = OP_REPLY; cmd.status = ST_REFUSED;
            end else begin
              cmd.op = OP_START;
            end
          end
          KIND_SPAWN: begin
            if (flags.q_full || !flags.id_avail) begin
              cmd.op = OP_REPLY; cmd.status = ST_REFUSED;
            end else begin
              cmd.op = OP_SPAWN;
            end
          end
          KIND_SCHED: begin
            if (!flags.core_ok) begin
              cmd.op = OP_REPLY; cmd.status = ST_MISSING;
            end else begin
              state_nxt = S_SCH_RD;
            end
          end
          KIND_EXIT: begin
            if (!flags.core_ok || flags.run_zero) begin
              cmd.op = OP_REPLY; cmd.status = ST_MISSING;
            end else begin
              cmd.op = OP_EXIT;
            end
          end
          KIND_KILL: begin
            if (flags.target_zero) begin
              cmd.op = OP_REPLY; cmd.status = ST_MISSING;
            end else begin
              cmd.op    = OP_KC_CLR;
              state_nxt = S_KC_CHK;
            end
          end
          KIND_QUERY: begin
            if (!flags.core_ok || flags.run_zero) begin
              cmd.op = OP_REPLY; cmd.status = ST_MISSING;
            end else begin
              cmd.op = OP_QUERY;
            end
          end
          default: begin
            cmd.op = OP_REPLY; cmd.status = ST_MISSING;
          end
        endcase
      end
      S_SCH_RD: begin
        if (flags.q_empty) begin
          cmd.op = OP_REPLY; cmd.status = ST_EMPTY;
          state_nxt = S_RESP;
        end else begin
          cmd.op    = OP_HEAD_RD;
          state_nxt = S_SCH_CHK;
        end
      end
      S_SCH_CHK: begin
        if (flags.head_dead) begin
          cmd.op    = OP_POP;
          state_nxt = S_SCH_RD;
        end else if (flags.run_zero) begin
          cmd.op = OP_REPLY; cmd.status = ST_MISSING;
          state_nxt = S_RESP;
        end else begin
          cmd.op    = OP_SWAP;
          state_nxt = S_RESP;
        end
      end
      S_KC_CHK: begin
        cmd.scan = 1'b1;
        if (flags.kc_end) begin
          cmd.op    = OP_KQ_CLR;
          state_nxt = S_KQ_RD;
        end else if (flags.kc_match) begin
          cmd.op    = OP_KC_HIT;
          state_nxt = S_RESP;
        end else begin
          cmd.op = OP_KC_NEXT;
        end
      end
      S_KQ_RD: begin
        if (flags.kq_end) begin
          cmd.op = OP_REPLY; cmd.status = ST_MISSING;
          state_nxt = S_RESP;
        end else begin
          cmd.op    = OP_KQ_RD;
          state_nxt = S_KQ_CHK;
        end
      end
      S_KQ_CHK: begin
        if (flags.kq_match) begin
          cmd.op    = OP_KQ_HIT;
          state_nxt = S_RESP;
        end else begin
          cmd.op    = OP_KQ_NEXT;
          state_nxt = S_KQ_RD;
        end
      end
      S_RESP: begin
        if (flags.out_free) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
    end
  end

  assign in_ready = in_ready_r;

endmodule

`default_nettype wire

// ===== rtl/core/rrtq_dp.sv =====
// Datapath for the round-robin task queue: task ring memory, per-core running
// registers, id counter, scan counters and result registers. Depends on rrtq_pkg.
`default_nettype none

module rrtq_dp #(
  parameter int QUEUE_DEPTH = 64,
  parameter int CORES       = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rrtq_pkg::rrtq_in_t    in_data,
  input  rrtq_pkg::rrtq_cmd_t   cmd,
  input  logic                  out_ready,
  output rrtq_pkg::rrtq_flags_t flags,
  output rrtq_pkg::rrtq_out_t   out_data,
  output logic                  out_valid
);
  import rrtq_pkg::*;

  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW  = $clog2(QUEUE_DEPTH + 1);
  localparam int SW  = FW + 1;
  localparam int CIW = (CORES > 1) ? $clog2(CORES) : 1;
  localparam int CNW = $clog2(CORES + 1);
  localparam int EW  = 32;
  localparam logic [PID_W-1:0] PID_LAST = '1;

  typedef struct packed {
    logic             dead;
    logic [PID_W-1:0] id;
  } entry_t;

  entry_t              mem [QUEUE_DEPTH];
  entry_t              rd_q_r;
  logic [QAW-1:0]      front_r;
  logic [FW-1:0]       fill_r;
  logic [PID_W-1:0]    run_id_r [CORES];
  logic                run_dead_r [CORES];
  logic [PID_W-1:0]    issued_r;
  logic [CNW-1:0]      core_idx_r;
  logic [FW-1:0]       q_off_r;
  rrtq_in_t            req_r;
  logic [1:0]          res_status_r;
  logic [PID_W-1:0]    res_pid_r;
  logic [PID_W-1:0]    res_prev_r;
  rrtq_out_t           out_r;
  logic                out_valid_r;

  logic [EW-1:0]       core_ext, target_ext, cur_ext, rd_ext, new_ext;
  logic                core_ok, kc_end;
  logic [CIW-1:0]      req_idx, scan_idx, rd_idx;
  logic [PID_W-1:0]    cur_id, new_id;
  logic                cur_dead;
  logic [FW-1:0]       off_sel;
  logic [SW-1:0]       slot_sum;
  logic [QAW-1:0]      slot, front_inc;
  logic                mem_we, mem_re;
  entry_t              mem_wdata;

  assign core_ext = EW'(req_r.core);
  assign core_ok  = core_ext < EW'(CORES);
  assign req_idx  = core_ok ? CIW'(req_r.core) : '0;
  assign scan_idx = core_idx_r[CIW-1:0];
  assign kc_end   = (core_idx_r == CNW'(CORES));
  assign rd_idx   = (cmd.scan && !kc_end) ? scan_idx : req_idx;
  assign cur_id   = run_id_r[rd_idx];
  assign cur_dead = run_dead_r[rd_idx];
  assign new_id   = issued_r + PID_W'(1);

  assign target_ext = EW'(req_r.target_pid);
  assign cur_ext    = EW'(cur_id);
  assign rd_ext     = EW'(rd_q_r.id);
  assign new_ext    = EW'(new_id);

  // Ring slot at an offset from the head
  always_comb begin
    case (cmd.op)
      OP_SPAWN, OP_SWAP:  off_sel = fill_r;
      OP_KQ_RD, OP_KQ_HIT: off_sel = q_off_r;
      default:            off_sel = '0;
    endcase
  end

  assign slot_sum  = SW'(front_r) + SW'(off_sel);
  assign slot      = (slot_sum >= SW'(QUEUE_DEPTH)) ? QAW'(slot_sum - SW'(QUEUE_DEPTH))
                                                    : QAW'(slot_sum);
  assign front_inc = (front_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : front_r + QAW'(1);

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_wdata = '{dead: 1'b0, id: new_id};
    case (cmd.op)
      OP_SPAWN: mem_we = 1'b1;
      OP_SWAP: begin
        mem_we    = 1'b1;
        mem_wdata = '{dead: cur_dead, id: cur_id};
      end
      OP_KQ_HIT: begin
        mem_we    = 1'b1;
        mem_wdata = '{dead: 1'b1, id: rd_q_r.id};
      end
      OP_HEAD_RD, OP_KQ_RD: mem_re = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[slot] <= mem_wdata;
    if (mem_re) rd_q_r <= mem[slot];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      fill_r      <= '0;
      issued_r    <= '0;
      core_idx_r  <= '0;
      q_off_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CORES; i++) begin
        run_id_r[i]   <= '0;
        run_dead_r[i] <= 1'b0;
      end
    end else begin
      case (cmd.op)
        OP_START: begin
          issued_r           <= new_id;
          run_id_r[req_idx]   <= new_id;
          run_dead_r[req_idx] <= 1'b0;
        end
        OP_SPAWN: begin
          issued_r <= new_id;
          fill_r   <= fill_r + FW'(1);
        end
        OP_POP: begin
          front_r <= front_inc;
          fill_r  <= fill_r - FW'(1);
        end
        OP_SWAP: begin
          front_r             <= front_inc;
          run_id_r[req_idx]   <= rd_q_r.id;
          run_dead_r[req_idx] <= 1'b0;
        end
        OP_EXIT:    run_dead_r[req_idx] <= 1'b1;
        OP_KC_CLR:  core_idx_r <= '0;
        OP_KC_NEXT: core_idx_r <= core_idx_r + CNW'(1);
        OP_KC_HIT:  run_dead_r[scan_idx] <= 1'b1;
        OP_KQ_CLR:  q_off_r <= '0;
        OP_KQ_NEXT: q_off_r <= q_off_r + FW'(1);
        default: ;
      endcase
      if (cmd.op == OP_LOAD) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: request, result and output beat
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LATCH: req_r <= in_data;
      OP_REPLY: begin
        res_status_r <= cmd.status;
        res_pid_r    <= '0;
        res_prev_r   <= '0;
      end
      OP_START, OP_SPAWN: begin
        res_status_r <= ST_OK;
        res_pid_r    <= new_ext[PID_W-1:0];
        res_prev_r   <= '0;
      end
      OP_SWAP: begin
        res_status_r <= ST_OK;
        res_pid_r    <= rd_ext[PID_W-1:0];
        res_prev_r   <= cur_ext[PID_W-1:0];
      end
      OP_EXIT, OP_QUERY: begin
        res_status_r <= ST_OK;
        res_pid_r    <= cur_ext[PID_W-1:0];
        res_prev_r   <= '0;
      end
      OP_KC_HIT, OP_KQ_HIT: begin
        res_status_r <= ST_OK;
        res_pid_r    <= req_r.target_pid;
        res_prev_r   <= '0;
      end
      OP_LOAD: begin
        out_r.status   <= res_status_r;
        out_r.pid      <= res_pid_r;
        out_r.prev_pid <= res_prev_r;
      end
      default: ;
    endcase
  end

  assign flags.kind        = req_r.kind;
  assign flags.core_ok     = core_ok;
  assign flags.id_avail    = (issued_r != PID_LAST);
  assign flags.q_full      = (fill_r == FW'(QUEUE_DEPTH));
  assign flags.q_empty     = (fill_r == '0);
  assign flags.run_zero    = (cur_id == '0);
  assign flags.head_dead   = rd_q_r.dead;
  assign flags.kc_end      = kc_end;
  assign flags.kc_match    = !kc_end && (cur_ext == target_ext);
  assign flags.kq_end      = (q_off_r == fill_r);
  assign flags.kq_match    = (rd_ext == target_ext);
  assign flags.target_zero = (req_r.target_pid == '0);
  assign flags.out_free    = !out_valid_r || out_ready;

  assign out_data  = out_r;
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== rtl/core/round_robin_task_queue_unit.sv =====
// Round-robin task queue: top level joining the sequencer and the datapath.
// Depends on rrtq_pkg, rrtq_ctrl and rrtq_dp.
// Usage: one request beat in on in_valid/in_ready (kind, core, target_pid),
// one result beat out on out_valid/out_ready (status, pid, prev_pid) for
// every request, in request order. Requests are handled one at a time.
// The ring walks are set by the single read port of the task ring memory:
// each entry takes a read state and a check state. in_ready returns the
// cycle after the result is loaded into the output register. A stalled
// result stays in the output register while the next request is accepted
// and worked on; that request then waits for the output register before
// finishing. Reset (rst_n low, synchronous) empties the ring, clears every
// core's running task and restarts ids at 1; the ring memory itself is not
// cleared, since only written entries are read.
`default_nettype none

module round_robin_task_queue_unit #(
  parameter int QUEUE_DEPTH = 64,
  parameter int CORES       = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rrtq_pkg::rrtq_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rrtq_pkg::rrtq_out_t out_data
);
  import rrtq_pkg::*;

  rrtq_cmd_t   cmd;
  rrtq_flags_t flags;

  // Sequencer: decode, walk the ring, hand back the beat
  rrtq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .flags    (flags),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  // Storage and result registers
  rrtq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .CORES       (CORES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_ready (out_ready),
    .flags     (flags),
    .out_data  (out_data),
    .out_valid (out_valid)
  );

  // Drop ready right after a request is taken: one request in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while another is in flight");

  // Load the output register only when it is empty or the pending beat leaves
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_LOAD) |-> (!out_valid || out_ready))
    else $error("result beat overwritten before it was taken");

  // A load always presents a beat
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_LOAD) |=> out_valid)
    else $error("loaded result not presented");

  // A core hit in the kill search lies inside the core range
  a_kill_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_KC_HIT) |-> !flags.kc_end)
    else $error("kill hit past the last core");

endmodule

`default_nettype wire

// ===== dv/rrtq_scoreboard.sv =====
`timescale 1ns / 1ps
// Scoreboard for the round-robin task queue: watches the request and result channels,
// keeps its own copy of the ring and core state, and compares every result beat.
// Depends on rrtq_pkg.
module rrtq_scoreboard #(
  parameter int QUEUE_DEPTH = 64,
  parameter int CORES       = 4,
  parameter int PID_BITS    = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  rrtq_pkg::rrtq_in_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  rrtq_pkg::rrtq_out_t out_data,
  output int                  error_count,
  output int                  outstanding
);
  import rrtq_pkg::*;

  localparam int SHOWN_MISMATCHES = 10;

  logic [PID_W-1:0]    ring_id   [QUEUE_DEPTH];
  logic                ring_dead [QUEUE_DEPTH];
  int                  ring_head;
  int                  ring_count;
  logic [PID_W-1:0]    core_task [CORES];
  logic                core_dead [CORES];
  logic [PID_BITS-1:0] ids_given;

  rrtq_out_t owed_replies[$];
  int        errs;

  function automatic int slot(input int off);
    return (ring_head + off) % QUEUE_DEPTH;
  endfunction

  function automatic void drop_head();
    ring_head  = (ring_head + 1) % QUEUE_DEPTH;
    ring_count = ring_count - 1;
  endfunction

  function automatic void push_tail(input logic [PID_W-1:0] id, input logic dead);
    ring_id[slot(ring_count)]   = id;
    ring_dead[slot(ring_count)] = dead;
    ring_count = ring_count + 1;
  endfunction

  // Apply one request to the shadow state and return its result beat.
  function automatic rrtq_out_t serve_request(input rrtq_in_t req);
    rrtq_out_t        res;
    int               c;
    int               i;
    logic             core_ok;
    logic             found;
    logic [PID_W-1:0] nxt;
    res     = '{status: ST_MISSING, pid: '0, prev_pid: '0};
    core_ok = int'(req.core) < CORES;
    c       = core_ok ? int'(req.core) : 0;
    found   = 1'b0;
    case (req.kind)
      KIND_START: begin
        if (core_ok) begin
          if (&ids_given) begin
            res.status = ST_REFUSED;
          end else begin
            ids_given    = ids_given + 1'b1;
            core_task[c] = PID_W'(ids_given);
            core_dead[c] = 1'b0;
            res.status   = ST_OK;
            res.pid      = PID_W'(ids_given);
          end
        end
      end
      KIND_SPAWN: begin
        if (ring_count >= QUEUE_DEPTH || &ids_given) begin
          res.status = ST_REFUSED;
        end else begin
          ids_given = ids_given + 1'b1;
          push_tail(PID_W'(ids_given), 1'b0);
          res.status = ST_OK;
          res.pid    = PID_W'(ids_given);
        end
      end
      KIND_SCHED: begin
        if (core_ok) begin
          while (ring_count != 0 && ring_dead[slot(0)]) drop_head();
          if (ring_count == 0) begin
            res.status = ST_EMPTY;
          end else if (core_task[c] != '0) begin
            nxt = ring_id[slot(0)];
            drop_head();
            res.prev_pid = core_task[c];
            push_tail(core_task[c], core_dead[c]);
            core_task[c] = nxt;
            core_dead[c] = 1'b0;
            res.status   = ST_OK;
            res.pid      = nxt;
          end
        end
      end
      KIND_EXIT: begin
        if (core_ok && core_task[c] != '0) begin
          core_dead[c] = 1'b1;
          res.status   = ST_OK;
          res.pid      = core_task[c];
        end
      end
      KIND_KILL: begin
        if (req.target_pid != '0) begin
          // running cores first, then the ring from head to tail
          for (i = 0; i < CORES && !found; i++) begin
            if (core_task[i] != '0 && core_task[i] == req.target_pid) begin
              core_dead[i] = 1'b1;
              found = 1'b1;
            end
          end
          for (i = 0; i < ring_count && !found; i++) begin
            if (ring_id[slot(i)] == req.target_pid) begin
              ring_dead[slot(i)] = 1'b1;
              found = 1'b1;
            end
          end
          if (found) begin
            res.status = ST_OK;
            res.pid    = req.target_pid;
          end
        end
      end
      KIND_QUERY: begin
        if (core_ok && core_task[c] != '0) begin
          res.status = ST_OK;
          res.pid    = core_task[c];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    rrtq_out_t want;
    if (!rst_n) begin
      ring_head  = 0;
      ring_count = 0;
      ids_given  = '0;
      for (int i = 0; i < CORES; i++) begin
        core_task[i] = '0;
        core_dead[i] = 1'b0;
      end
      owed_replies.delete();
      errs = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (owed_replies.size() == 0) begin
          errs++;
          if (errs <= SHOWN_MISMATCHES)
            $display("%0t: result beat with no request owed: status %0d pid %0d prev %0d",
                     $realtime, out_data.status, out_data.pid, out_data.prev_pid);
        end else begin
          want = owed_replies.pop_front();
          if (out_data.status !== want.status || out_data.pid !== want.pid ||
              out_data.prev_pid !== want.prev_pid) begin
            errs++;
            if (errs <= SHOWN_MISMATCHES)
              $display("%0t: mismatch status exp %0d got %0d, pid exp %0d got %0d, prev exp %0d got %0d",
                       $realtime, want.status, out_data.status, want.pid, out_data.pid,
                       want.prev_pid, out_data.prev_pid);
          end
        end
      end
      if (in_valid && in_ready) owed_replies.push_back(serve_request(in_data));
    end
    error_count <= errs;
    outstanding <= owed_replies.size();
  end

endmodule

// ===== dv/round_robin_task_queue_unit_test.sv =====
`timescale 1ns / 1ps
// Top of the round-robin task queue testbench: clock, reset, request and result-side
// stimulus, watchdog and verdict. Depends on rrtq_pkg, rrtq_scoreboard and the block.
module round_robin_task_queue_unit_test;
  import rrtq_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_ITEMS   = 1250;
  localparam int SETTLE_CYCLES  = 200;

  // Kinds the block does not define; it must answer them as missing.
  localparam logic [2:0] KIND_RSVD6 = 3'd6;
  localparam logic [2:0] KIND_RSVD7 = 3'd7;

  // Request mixes: grow fills the ring, churn keeps it busy, drain empties it.
  typedef enum logic [1:0] {MIX_GROW, MIX_CHURN, MIX_DRAIN} mix_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  rrtq_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  rrtq_out_t out_data;

  logic idle_allowed = 1'b1;  // random gaps on both sides while high
  int   ids_sent     = 0;     // start and spawn requests sent, an upper bound on ids
  int   error_count;
  int   outstanding;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  round_robin_task_queue_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  rrtq_scoreboard u_scoreboard (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .error_count (error_count),
    .outstanding (outstanding)
  );

  // Offer one request beat and hold it until accepted. An optional idle burst
  // comes first; valid is lowered only at that point, so it never drops and
  // rises in the same step.
  task automatic send_request(input logic [2:0] kind, input logic [1:0] core,
                              input logic [PID_W-1:0] tgt);
    if (idle_allowed && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    if (kind == KIND_START || kind == KIND_SPAWN) ids_sent++;
    in_valid <= 1'b1;
    in_data  <= '{kind: kind, core: core, target_pid: tgt};
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and hold off until every owed result beat has come back.
  // Let the scoreboard see the last request first so its count includes it.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Draw one request from the given mix. Kill targets lean toward recent ids,
  // which are the ones most likely to still be running or waiting.
  task automatic random_request(input mix_t mix);
    int               roll;
    int               pick;
    int               back;
    int               t_start;
    int               t_spawn;
    int               t_sched;
    int               t_exit;
    int               t_kill;
    logic [2:0]       kind;
    logic [PID_W-1:0] tgt;
    case (mix)
      MIX_GROW: begin
        t_start = 5; t_spawn = 50; t_sched = 75; t_exit = 80; t_kill = 90;
      end
      MIX_CHURN: begin
        t_start = 5; t_spawn = 20; t_sched = 55; t_exit = 70; t_kill = 90;
      end
      default: begin
        t_start = 2; t_spawn = 5; t_sched = 40; t_exit = 60; t_kill = 90;
      end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < t_start)      kind = KIND_START;
    else if (roll < t_spawn) kind = KIND_SPAWN;
    else if (roll < t_sched) kind = KIND_SCHED;
    else if (roll < t_exit)  kind = KIND_EXIT;
    else if (roll < t_kill)  kind = KIND_KILL;
    else if (roll < 97)      kind = KIND_QUERY;
    else                     kind = $urandom_range(0, 1) ? KIND_RSVD7 : KIND_RSVD6;
    tgt = PID_W'($urandom);
    if (kind == KIND_KILL) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        tgt = '0;
      end else if (pick > 1) begin
        back = $urandom_range(0, 70);
        tgt  = (ids_sent > back) ? PID_W'(ids_sent - back) : PID_W'(1);
      end
    end
    send_request(kind, 2'($urandom_range(0, 3)), tgt);
  endtask

  // Result side: ready in runs of random length, broken by stalls while idling
  // is allowed. Some runs are long, giving stall-free stretches.
  initial begin : result_side
    int run_len;
    while (!rst_n) @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 24);
      repeat (run_len) @(posedge clk);
      if (idle_allowed) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // Watchdog: end the run if neither channel moves a beat for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    mix_t mix;
    int   sent;
    int   burst;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. Ids come out in order, so the numbers below are known:
    // spawn gives 1, starts give 2..6, the later spawns give 7 and 8.
    send_request(KIND_QUERY, 2'd0, 16'hFFFF);     // query with no running task
    send_request(KIND_EXIT,  2'd1, 16'h0000);     // exit with no running task
    send_request(KIND_SCHED, 2'd2, 16'hA5A5);     // schedule on an empty ring
    send_request(KIND_SPAWN, 2'd0, 16'h5A5A);
    send_request(KIND_SCHED, 2'd3, 16'h0000);     // live task waiting, core has none
    send_request(KIND_START, 2'd0, 16'h0000);
    send_request(KIND_START, 2'd1, 16'hFFFF);
    send_request(KIND_START, 2'd2, 16'h0000);
    send_request(KIND_START, 2'd3, 16'hFFFF);
    send_request(KIND_START, 2'd3, 16'h1234);     // busy core: task replaced, not requeued
    send_request(KIND_SPAWN, 2'd0, 16'h0000);
    send_request(KIND_SPAWN, 2'd3, 16'hFFFF);
    send_request(KIND_KILL,  2'd0, 16'h0000);     // kill of id zero
    send_request(KIND_KILL,  2'd3, 16'hFFFF);     // kill of an unknown id
    send_request(KIND_KILL,  2'd1, 16'd3);        // hits a running core
    send_request(KIND_KILL,  2'd2, 16'd1);        // hits the ring head
    send_request(KIND_KILL,  2'd0, 16'd7);        // hits deeper in the ring
    send_request(KIND_SCHED, 2'd0, 16'h0000);     // drain two dead heads, then switch
    send_request(KIND_EXIT,  2'd2, 16'h0000);
    send_request(KIND_SCHED, 2'd2, 16'hFFFF);     // requeue a dead task at the tail
    send_request(KIND_QUERY, 2'd1, 16'h0000);     // dead but still running
    send_request(KIND_RSVD6, 2'd0, 16'hFFFF);
    send_request(KIND_RSVD7, 2'd3, 16'($urandom));
    send_request(KIND_SCHED, 2'd1, 16'h0000);     // only a dead head left: nothing to switch
    send_request(KIND_QUERY, 2'd3, 16'hFFFF);
    wait_for_drain();

    // Random part in bursts of one mix each; start growing so the ring fills.
    sent = 0;
    mix  = MIX_GROW;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(60, 140);
      repeat (burst) begin
        random_request(mix);
        sent++;
      end
      mix = mix_t'($urandom_range(0, 2));
      if ($urandom_range(0, 2) == 0) wait_for_drain();
    end
    wait_for_drain();

    // Last part, no idling on either side: a run of back-to-back requests.
    idle_allowed <= 1'b0;
    repeat (24) random_request(MIX_CHURN);

    // Drain, then wait out the settling period to catch stray result beats.
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/rrtq_pkg.sv
rtl/core/rrtq_ctrl.sv
rtl/core/rrtq_dp.sv
rtl/core/round_robin_task_queue_unit.sv
dv/rrtq_scoreboard.sv
dv/round_robin_task_queue_unit_test.sv
